### sv/hvg_pkg.sv
// shared types and constants for the horizon visibility graph edge unit
// no dependencies; imported by the cell, the scan unit and the top level
`default_nettype none

package hvg_pkg;

    localparam int MAX_HORIZON_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int INDEX_BITS_DEF  = 32;

    localparam int               HORIZON_BITS  = 7;
    localparam [HORIZON_BITS-1:0] HORIZON_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // rot: every cell takes the sample of its older neighbor (head walks back in time)
    // ins: every cell takes the sample of its newer neighbor (new sample enters cell 0)
    typedef struct packed {
        logic rot;
        logic ins;
    } cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic check;
        logic flush;
    } scan_ctrl_t;

endpackage

`default_nettype wire

### sv/horizon_visibility_graph_edges_unit.sv
// sequence per item: accept, one chain rotation per chain cell, insert; the rotation and
// insert steps wait while the output is stalled; one item at a time
// throughput: at most one edge per cycle, edges delayed by one visible step for last_edge
// the chain makes a full turn of MAX_HORIZON cells per item, which sets the item time
// reset: index, fill count and control cleared, horizon set to 64; stored samples undefined
// top level: chain of hvg_cell, hvg_scan, sequencer; depends on hvg_pkg
`default_nettype none

module horizon_visibility_graph_edges_unit
    import hvg_pkg::*;
#(
    parameter int MAX_HORIZON = MAX_HORIZON_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [HORIZON_BITS-1:0] horizon,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_BITS-1:0]  sample,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [INDEX_BITS-1:0]   older_index,
    output logic      [INDEX_BITS-1:0]   newer_index,
    output logic                         last_edge
);

    localparam int DW = $clog2(MAX_HORIZON + 1);
    localparam int LW = (DW > HORIZON_BITS) ? DW : HORIZON_BITS;

    state_t                  state_reg, state_next;
    logic [HORIZON_BITS-1:0] horizon_reg, horizon_next;
    logic [INDEX_BITS-1:0]   count_reg, count_next;
    logic [DW-1:0]           fill_reg, fill_next;
    logic [DW-1:0]           dist_reg, dist_next;
    logic [DW-1:0]           lim_reg, lim_next;
    logic [SAMPLE_BITS-1:0]  xj_reg, xj_next;

    logic [LW-1:0]           h_ext;
    logic [LW-1:0]           hsat;
    logic [DW-1:0]           hsat_d;
    logic                    out_free;
    logic                    accept;
    cell_ctrl_t              cell_ctrl;
    scan_ctrl_t              scan_ctrl;
    logic [SAMPLE_BITS-1:0]  chain [MAX_HORIZON];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    // horizon above the chain length saturates, then short history limits it further
    assign h_ext  = LW'(horizon_reg);
    assign hsat   = (h_ext > LW'(MAX_HORIZON)) ? LW'(MAX_HORIZON) : h_ext;
    assign hsat_d = hsat[DW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        horizon_next = horizon_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        dist_next    = dist_reg;
        lim_next     = lim_reg;
        xj_next      = xj_reg;
        cell_ctrl    = '0;
        scan_ctrl    = '0;

        if (cfg_valid && cfg_ready)
        begin
            horizon_next = horizon;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    xj_next         = sample;
                    dist_next       = DW'(1);
                    lim_next        = (hsat_d > fill_reg) ? fill_reg : hsat_d;
                    scan_ctrl.start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    scan_ctrl.check = (dist_reg <= lim_reg);
                    cell_ctrl.rot   = 1'b1;
                    if (dist_reg == DW'(MAX_HORIZON))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        dist_next = dist_reg + DW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    scan_ctrl.flush = 1'b1;
                    cell_ctrl.ins   = 1'b1;
                    count_next      = count_reg + INDEX_BITS'(1);
                    if (fill_reg != DW'(MAX_HORIZON))
                    begin
                        fill_next = fill_reg + DW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            horizon_reg <= HORIZON_RESET;
            count_reg   <= '0;
            fill_reg    <= '0;
            dist_reg    <= '0;
            lim_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            horizon_reg <= horizon_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            dist_reg    <= dist_next;
            lim_reg     <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xj_reg <= xj_next;
    end

    // cell 0 holds the newest stored sample; rotation walks older samples into cell 0
    // and a full turn of MAX_HORIZON steps restores the order
    for (genvar k = 0; k < MAX_HORIZON; k++)
    begin : g_chain
        logic [SAMPLE_BITS-1:0] newer_side;
        logic [SAMPLE_BITS-1:0] older_side;

        if (k == 0)
        begin : g_first
            assign newer_side = xj_reg;
        end
        else
        begin : g_mid
            assign newer_side = chain[k-1];
        end

        if (k == MAX_HORIZON - 1)
        begin : g_wrap
            assign older_side = chain[0];
        end
        else
        begin : g_next
            assign older_side = chain[k+1];
        end

        hvg_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .from_newer (newer_side),
            .from_older (older_side),
            .value      (chain[k])
        );
    end

    hvg_scan #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .DIST_BITS   (DW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .head        (chain[0]),
        .xj          (xj_reg),
        .scan_dist   (dist_reg),
        .newer       (count_reg),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .older_index (older_index),
        .newer_index (newer_index),
        .last_edge   (last_edge)
    );

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (dist_reg == DW'(1)))
        else $error("accepted item did not start a scan at distance one");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (dist_reg != '0) && (dist_reg <= DW'(MAX_HORIZON)))
        else $error("scan distance out of range");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= DW'(MAX_HORIZON)) && (lim_reg <= fill_reg || state_reg == ST_IDLE))
        else $error("fill count or scan limit out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && out_free |=> (count_reg == $past(count_reg) + INDEX_BITS'(1)))
        else $error("sample index did not advance after an item");

endmodule

`default_nettype wire

### sv/hvg_cell.sv
// one cell of the sample chain: holds one stored sample
// depends on hvg_pkg for the chain control struct
`default_nettype none

module hvg_cell
    import hvg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire cell_ctrl_t             ctrl,
    input  wire logic [SAMPLE_BITS-1:0] from_newer,
    input  wire logic [SAMPLE_BITS-1:0] from_older,
    output logic      [SAMPLE_BITS-1:0] value
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            value_next = from_newer;
        end
        else if (ctrl.rot)
        begin
            value_next = from_older;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### sv/hvg_scan.sv
// visibility test against the running maximum slope, pending edge and output register
// depends on hvg_pkg for the scan control struct
`default_nettype none

module hvg_scan
    import hvg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int DIST_BITS   = 7
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire scan_ctrl_t             ctrl,
    input  wire logic [SAMPLE_BITS-1:0] head,
    input  wire logic [SAMPLE_BITS-1:0] xj,
    input  wire logic [DIST_BITS-1:0]   scan_dist,
    input  wire logic [INDEX_BITS-1:0]  newer,
    output logic                        out_free,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [INDEX_BITS-1:0]  older_index,
    output logic      [INDEX_BITS-1:0]  newer_index,
    output logic                        last_edge
);

    localparam int NW = SAMPLE_BITS + 1;
    localparam int PW = NW + DIST_BITS + 1;
    localparam int EW = (INDEX_BITS > DIST_BITS) ? INDEX_BITS : DIST_BITS;

    logic                  have_best_reg, have_best_next;
    logic signed [NW-1:0]  best_num_reg, best_num_next;
    logic [DIST_BITS-1:0]  best_den_reg, best_den_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [DIST_BITS-1:0]  pend_dist_reg, pend_dist_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0] older_reg, older_next;
    logic [INDEX_BITS-1:0] newer_reg, newer_next;
    logic                  last_reg, last_next;

    logic signed [NW-1:0]          num;
    logic signed [DIST_BITS:0]     den_s;
    logic signed [DIST_BITS:0]     dist_s;
    logic signed [PW-1:0]          lhs;
    logic signed [PW-1:0]          rhs;
    logic                          vis;
    logic [EW-1:0]                 older_wide;

    assign num    = $signed({head[SAMPLE_BITS-1], head}) - $signed({xj[SAMPLE_BITS-1], xj});
    assign den_s  = $signed({1'b0, best_den_reg});
    assign dist_s = $signed({1'b0, scan_dist});
    // exact compare of num/scan_dist against best_num/best_den, both denominators positive
    assign lhs    = num * den_s;
    assign rhs    = best_num_reg * dist_s;
    assign vis    = !have_best_reg || (lhs > rhs);

    assign older_wide = EW'(newer) - EW'(pend_dist_reg);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        have_best_next  = have_best_reg;
        best_num_next   = best_num_reg;
        best_den_next   = best_den_reg;
        pend_valid_next = pend_valid_reg;
        pend_dist_next  = pend_dist_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        older_next      = older_reg;
        newer_next      = newer_reg;
        last_next       = last_reg;

        if (ctrl.start)
        begin
            have_best_next  = 1'b0;
            pend_valid_next = 1'b0;
        end
        else if (ctrl.check && vis)
        begin
            // a newer visible edge means the pending one is not the last
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                older_next     = older_wide[INDEX_BITS-1:0];
                newer_next     = newer;
                last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_dist_next  = scan_dist;
            have_best_next  = 1'b1;
            best_num_next   = num;
            best_den_next   = scan_dist;
        end
        else if (ctrl.flush && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            older_next      = older_wide[INDEX_BITS-1:0];
            newer_next      = newer;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_best_reg  <= have_best_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_num_reg  <= best_num_next;
        best_den_reg  <= best_den_next;
        pend_dist_reg <= pend_dist_next;
        older_reg     <= older_next;
        newer_reg     <= newer_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign older_index = older_reg;
    assign newer_index = newer_reg;
    assign last_edge   = last_reg;

endmodule

`default_nettype wire
